// ===== rtl/core/plc_pkg.sv =====
`default_nettype none
package plc_pkg;

  localparam int CODE_W    = 16;
  localparam int VALUE_W   = 32;
  localparam int INDEX_W   = 4;
  localparam int COUNT_W   = 5;
  localparam int NUM_W     = 48;
  localparam int DIV_STEPS = 48;
  localparam int STEP_W    = 6;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_CONVERT = 1'b1;

  typedef struct packed {
    logic load;
    logic capture;
    logic first;
    logic shift;
    logic take;
    logic mul;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic below;
    logic zero_div;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/piecewise_linear_calibrator.sv =====
// Piecewise linear calibrator: maps 16-bit ADC codes to signed Q16.16 values
// through a table of up to MAX_POINTS breakpoints.
// Input stream (s_*): s_tuser is the kind, 0 loads a breakpoint, 1 converts.
//   A load writes slot point_index and produces no result; the next request
//   is taken in the following cycle.
// Output stream (m_*): one result per convert, with the fault flag in tuser.
// Config channel (cfg_*): point_count, always ready; write it only while idle.
// A convert goes from accept to m_tvalid through the segment search, with
// one table read per cycle, a multiply step, a 48-step restoring divider
// and a saturation step. A segment with equal end codes skips the divider.
// One convert is in flight at a time.
// The result sits in an output register; a stalled receiver holds it there
// and the block still accepts and starts the next request, finishing it only
// once the register is free.
// Reset clears the control state and sets point_count to 16; the breakpoint
// table holds no defined value until loaded.
`default_nettype none
module piecewise_linear_calibrator
  import plc_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [55:0]        s_tdata,  // point_index, adc_code, point_value, zero pad
  input  wire logic               s_tuser,  // kind
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic      [31:0]        m_tdata,  // result_value
  output logic                    m_tuser,  // divide_fault
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [COUNT_W-1:0] cfg_data
);

  cmd_t                          cmd;
  status_t                       st;
  logic [$clog2(MAX_POINTS)-1:0] rd_addr;

  assign cfg_ready = 1'b1;

  plc_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_kind   (s_tuser),
    .in_index  (s_tdata[3:0]),
    .in_ready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .st        (st),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  plc_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .in_index     (s_tdata[3:0]),
    .in_code      (s_tdata[19:4]),
    .in_value     (s_tdata[51:20]),
    .st           (st),
    .result_value (m_tdata),
    .divide_fault (m_tuser)
  );

endmodule
`default_nettype wire

// ===== rtl/core/plc_ram.sv =====
`default_nettype none
module plc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/plc_datapath.sv =====
`default_nettype none
module plc_datapath
  import plc_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  wire logic                          clk,
  input  wire cmd_t                          cmd,
  input  wire logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  input  wire logic [INDEX_W-1:0]            in_index,
  input  wire logic [CODE_W-1:0]             in_code,
  input  wire logic [VALUE_W-1:0]            in_value,
  output status_t                            st,
  output logic      [VALUE_W-1:0]            result_value,
  output logic                               divide_fault
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int EW = CODE_W + VALUE_W;
  localparam int SW = NUM_W + 2;

  logic [EW-1:0]      rd_data;
  logic [CODE_W-1:0]  rd_code;
  logic [CODE_W-1:0]  sample;
  logic               below;
  logic [CODE_W-1:0]  prev_code;
  logic [VALUE_W-1:0] prev_value;
  logic [CODE_W-1:0]  right_code;
  logic [VALUE_W-1:0] right_value;
  logic [NUM_W-1:0]   num;
  logic [CODE_W-1:0]  rem;
  logic [CODE_W-1:0]  dvsr;
  logic               neg;
  logic               fault;

  logic [CODE_W:0]    dx;
  logic [CODE_W:0]    dc;
  logic [VALUE_W:0]   dv;
  logic [CODE_W-1:0]  dx_mag;
  logic [CODE_W-1:0]  dc_mag;
  logic [VALUE_W:0]   dv_mag;
  logic [CODE_W+VALUE_W:0] prod;
  logic [CODE_W:0]    trial;
  logic               ge;
  logic [SW-1:0]      q_ext;
  logic [SW-1:0]      sum;

  plc_ram #(.WIDTH(EW), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (IW'(in_index)),
    .wdata ({in_code, in_value}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_code = rd_data[EW-1:VALUE_W];
  assign st      = {sample < rd_code, below, right_code == prev_code};

  always_comb begin
    dx     = {1'b0, sample} - {1'b0, prev_code};
    dc     = {1'b0, right_code} - {1'b0, prev_code};
    dv     = {right_value[VALUE_W-1], right_value} - {prev_value[VALUE_W-1], prev_value};
    dx_mag = dx[CODE_W] ? CODE_W'(-dx) : dx[CODE_W-1:0];
    dc_mag = dc[CODE_W] ? CODE_W'(-dc) : dc[CODE_W-1:0];
    dv_mag = dv[VALUE_W] ? -dv : dv;
    prod   = dx_mag * dv_mag;
    trial  = {rem, num[NUM_W-1]};
    ge     = trial >= {1'b0, dvsr};
    q_ext  = neg ? -{2'b00, num} : {2'b00, num};
    sum    = {{(SW-VALUE_W){prev_value[VALUE_W-1]}}, prev_value} + q_ext;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample <= in_code;
    end
    if (cmd.first) begin
      below <= sample < rd_code;
    end
    if (cmd.first || cmd.shift) begin
      prev_code  <= rd_code;
      prev_value <= rd_data[VALUE_W-1:0];
    end
    if (cmd.take) begin
      right_code  <= rd_code;
      right_value <= rd_data[VALUE_W-1:0];
    end
    if (cmd.mul) begin
      num   <= st.zero_div ? '0 : prod[NUM_W-1:0];
      neg   <= dx[CODE_W] ^ dv[VALUE_W] ^ dc[CODE_W];
      dvsr  <= dc_mag;
      rem   <= '0;
      fault <= st.zero_div;
    end
    if (cmd.div_step) begin
      rem <= ge ? CODE_W'(trial - {1'b0, dvsr}) : trial[CODE_W-1:0];
      num <= {num[NUM_W-2:0], ge};
    end
    if (cmd.finish) begin
      divide_fault <= fault;
      if (!sum[SW-1] && (sum[SW-2:VALUE_W-1] != '0)) begin
        result_value <= {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (sum[SW-1] && (sum[SW-2:VALUE_W-1] != '1)) begin
        result_value <= {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
        result_value <= sum[VALUE_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/plc_ctrl.sv =====
`default_nettype none
module plc_ctrl
  import plc_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic                          in_kind,
  input  wire logic [INDEX_W-1:0]            in_index,
  output logic                               in_ready,
  input  wire logic                          cfg_valid,
  input  wire logic [COUNT_W-1:0]            cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  input  wire status_t                       st,
  output cmd_t                               cmd,
  output logic      [$clog2(MAX_POINTS)-1:0] rd_addr
);

  localparam int IW = $clog2(MAX_POINTS);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FIRST = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      idx_next;
  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  step_next;
  logic [COUNT_W-1:0] point_count;
  logic               out_valid_next;
  logic [IW-1:0]      last;

  always_comb begin
    if (int'(point_count) < 2 || int'(point_count) >= MAX_POINTS) begin
      last = IW'(MAX_POINTS - 1);
    end else begin
      last = IW'(point_count - COUNT_W'(1));
    end
  end

  always_comb begin
    cmd            = '0;
    state_next     = state;
    idx_next       = idx;
    step_next      = step;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    rd_addr        = IW'(idx + IW'(1));
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = '0;
        idx_next = '0;
        if (in_valid) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load = int'(in_index) < MAX_POINTS;
          end else begin
            cmd.capture = 1'b1;
            state_next  = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        cmd.first  = 1'b1;
        idx_next   = IW'(idx + IW'(1));
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (st.below || st.hit || idx == last) begin
          cmd.take   = 1'b1;
          state_next = ST_MUL;
        end else begin
          cmd.shift = 1'b1;
          idx_next  = IW'(idx + IW'(1));
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        step_next  = '0;
        state_next = st.zero_div ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = STEP_W'(step + STEP_W'(1));
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      point_count <= COUNT_RESET;
      idx         <= '0;
      step        <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      idx       <= idx_next;
      step      <= step_next;
      if (cfg_valid) begin
        point_count <= cfg_data;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/plc_checker.sv =====
`default_nettype none
module plc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

  a_load: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> s_tready)
    else $error("load request left block busy");

  a_convert: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready ##1 !s_tready)
    else $error("convert request did not occupy block");

endmodule

bind piecewise_linear_calibrator plc_checker u_plc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
